FILE: rtl/core/vt100_pkg.sv
package vt100_pkg;

   localparam int MaxParams = 16;
   localparam int PidxW = $clog2(MaxParams);
   localparam int PcntW = $clog2(MaxParams + 1);

   typedef enum logic [1:0] {
      PS_GROUND = 2'd0,
      PS_ESC    = 2'd1,
      PS_CSI    = 2'd2,
      PS_SKIP   = 2'd3
   } parse_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_DECIDE,
      SQ_SGR,
      SQ_DIGIT,
      SQ_EMIT,
      SQ_HOLD
   } seq_type;

   localparam logic [3:0] CMD_GLYPH   = 4'd0;
   localparam logic [3:0] CMD_BS      = 4'd1;
   localparam logic [3:0] CMD_TAB     = 4'd2;
   localparam logic [3:0] CMD_LF      = 4'd3;
   localparam logic [3:0] CMD_CR      = 4'd4;
   localparam logic [3:0] CMD_NEWLINE = 4'd5;
   localparam logic [3:0] CMD_PLACE   = 4'd6;
   localparam logic [3:0] CMD_ED0     = 4'd7;
   localparam logic [3:0] CMD_EL0     = 4'd10;
   localparam logic [3:0] CMD_ATTR    = 4'd13;
   localparam logic [3:0] CMD_CLEAR   = 4'd14;

   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_DEL = 8'h7F;

   // one queued result word
   typedef struct packed {
      logic               kind;
      logic [3:0]         command;
      logic signed [17:0] row;
      logic signed [17:0] col;
      logic [7:0]         value;
   } res_type;

endpackage

FILE: rtl/core/vt100_escape_parser_top.sv
// vt100 escape parser
// req channel: one word per host byte or special key; tdata holds, from bit 0 up,
// rx_byte[7:0], key_code[10:8], cursor_row[18:11], cursor_col[26:19],
// screen_attr[34:27], zero fill to 40 bits; tuser is req_type.
// rsp channel: zero to ten words per request; tdata holds command[3:0],
// target_row[21:4], target_col[39:22], value[47:40], app_cursor_mode[48],
// ansi_mode[49], zero fill to 56 bits; tuser is kind; tlast marks the final
// word of the request.
// one request at a time: the request is accepted and decoded, then the result
// words go one by one into the output register (only a check when there is none).
// a csi final adds a dispatch step, the shared decimal unit works through the
// digits of a status report, and select graphic rendition walks the stored
// parameters one per cycle (up to 16) before its attribute word is queued.
// sgr with 16 parameters is the worst case, ahead of a cursor position report;
// stalls on rsp_tready while a word waits lengthen any request. The output
// register holds while rsp_tready is low; a new request may be taken while the
// last word waits.
// reset: parser in ground, modes to ansi with normal cursor keys, no saved
// cursor, no request pending.
module vt100_escape_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // rx_byte, key_code, cursor_row, cursor_col, screen_attr
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // command, target_row, target_col, value, app, ansi
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast
);
   import vt100_pkg::*;

   // captured request
   logic       typ_ff;
   logic [7:0] byt_ff, row_ff, col_ff, attr_ff;
   logic [2:0] key_ff;

   // parser state
   parse_type            ps_ff, ps_in;
   logic [15:0]          pstore [MaxParams];
   logic [PcntW-1:0]     pcnt_ff, pcnt_in;
   logic [15:0]          acc_ff, acc_in;
   logic                 hd_ff, hd_in, priv_ff, priv_in;
   logic                 sv_ff, sv_in;
   logic                 sv_wr;
   logic [7:0]           srow_ff, scol_ff, sattr_ff;
   logic                 app_ff, app_in, ansi_ff, ansi_in;

   // sequencer
   seq_type              sq_ff, sq_in;
   res_type              q_ff [10];
   res_type              q_in [10];
   logic [3:0]           qn_ff, qn_in, qi_ff, qi_in;
   logic [PcntW-1:0]     si_ff, si_in;
   logic [7:0]           sa_ff, sa_in;
   // decimal unit for status report
   logic [8:0]           dnum_ff, dnum_in;
   logic                 dsec_ff, dsec_in;
   logic [11:0]          dig_ff, dig_in;
   logic [1:0]           dk_ff, dk_in;

   logic                 pwr;
   logic [PidxW-1:0]     pwa;
   logic [15:0]          pwd;
   res_type              ovr_ff;
   logic                 ov_ff, ol_ff;
   logic                 ov_in, ol_in;
   res_type              ovr_in;
   logic                 oapp_ff, oapp_in, oansi_ff, oansi_in;

   function automatic res_type mk(input logic k, input logic [3:0] c,
                                  input logic signed [17:0] r,
                                  input logic signed [17:0] cl, input logic [7:0] v);
      res_type t;
      t.kind = k; t.command = c; t.row = r; t.col = cl; t.value = v;
      return t;
   endfunction

   // argument fetch
   logic [15:0] a0, a1;
   logic [17:0] d0, d1;
   always_comb begin
      a0 = (pcnt_ff > 0) ? pstore[0] : 16'd0;
      a1 = (pcnt_ff > 1) ? pstore[1] : 16'd0;
      d0 = (a0 == 16'd0) ? 18'd1 : {2'b00, a0};
      d1 = (a1 == 16'd0) ? 18'd1 : {2'b00, a1};
   end

   assign req_tready = (sq_ff == SQ_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = ovr_ff.kind;
   assign rsp_tlast  = ol_ff;
   assign rsp_tdata  = {6'd0, oansi_ff, oapp_ff, ovr_ff.value, ovr_ff.col,
                        ovr_ff.row, ovr_ff.command};

   // parameter store
   always_ff @(posedge clock) begin
      if (pwr) pstore[pwa] <= pwd;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff <= SQ_IDLE; ps_ff <= PS_GROUND; pcnt_ff <= '0; acc_ff <= '0;
         hd_ff <= 1'b0; priv_ff <= 1'b0; sv_ff <= 1'b0; app_ff <= 1'b0;
         ansi_ff <= 1'b1; ov_ff <= 1'b0;
      end else begin
         sq_ff <= sq_in; ps_ff <= ps_in; pcnt_ff <= pcnt_in; acc_ff <= acc_in;
         hd_ff <= hd_in; priv_ff <= priv_in; sv_ff <= sv_in; app_ff <= app_in;
         ansi_ff <= ansi_in; ov_ff <= ov_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         typ_ff <= req_tuser; byt_ff <= req_tdata[7:0]; key_ff <= req_tdata[10:8];
         row_ff <= req_tdata[18:11]; col_ff <= req_tdata[26:19];
         attr_ff <= req_tdata[34:27];
      end
      if (sv_wr) begin
         srow_ff <= row_ff; scol_ff <= col_ff; sattr_ff <= attr_ff;
      end
      q_ff <= q_in; qn_ff <= qn_in; qi_ff <= qi_in; si_ff <= si_in; sa_ff <= sa_in;
      dnum_ff <= dnum_in; dsec_ff <= dsec_in; dig_ff <= dig_in; dk_ff <= dk_in;
      ovr_ff <= ovr_in; ol_ff <= ol_in; oapp_ff <= oapp_in; oansi_ff <= oansi_in;
   end

   // sequencer and parser
   always_comb begin
      logic [19:0] prod;
      logic [3:0]  dval;
      logic [8:0]  quo;
      logic [17:0] r, c;
      logic        pushf, csifin;
      res_type     t;
      sq_in = sq_ff; ps_in = ps_ff; pcnt_in = pcnt_ff; acc_in = acc_ff;
      hd_in = hd_ff; priv_in = priv_ff; sv_in = sv_ff; app_in = app_ff;
      ansi_in = ansi_ff; q_in = q_ff; qn_in = qn_ff; qi_in = qi_ff;
      si_in = si_ff; sa_in = sa_ff; dnum_in = dnum_ff; dsec_in = dsec_ff;
      dig_in = dig_ff; dk_in = dk_ff; ov_in = ov_ff; ovr_in = ovr_ff; ol_in = ol_ff;
      oapp_in = oapp_ff; oansi_in = oansi_ff; sv_wr = 1'b0;
      pwr = 1'b0; pwa = '0; pwd = '0; prod = '0; dval = '0; quo = '0;
      r = {10'd0, row_ff}; c = {10'd0, col_ff}; pushf = 1'b0; csifin = 1'b0;
      t = mk(1'b0, CMD_GLYPH, '0, '0, '0);
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (sq_ff)
         SQ_IDLE: begin
            if (req_tvalid) sq_in = SQ_DECIDE;
         end
         SQ_DECIDE: begin
            qn_in = 4'd0; qi_in = 4'd0; sq_in = SQ_EMIT;
            if (typ_ff) begin
               if (key_ff < 3'd5) begin
                  q_in[0] = mk(1'b1, CMD_GLYPH, '0, '0, CH_ESC);
                  q_in[1] = mk(1'b1, CMD_GLYPH, '0, '0, app_ff ? "O" : "[");
                  q_in[2] = mk(1'b1, CMD_GLYPH, '0, '0,
                               (key_ff == 3'd4) ? "H" : 8'h41 + {5'd0, key_ff});
                  qn_in = 4'd3;
               end
            end else begin
               case (ps_ff)
                  PS_GROUND: begin
                     if (byt_ff == CH_ESC) ps_in = PS_ESC;
                     else if (byt_ff < 8'h20) begin
                        qn_in = 4'd1;
                        case (byt_ff)
                           8'h08: q_in[0] = mk(1'b0, CMD_BS, '0, '0, '0);
                           8'h09: q_in[0] = mk(1'b0, CMD_TAB, '0, '0, '0);
                           8'h0A, 8'h0B, 8'h0C: q_in[0] = mk(1'b0, CMD_LF, '0, '0, '0);
                           8'h0D: q_in[0] = mk(1'b0, CMD_CR, '0, '0, '0);
                           default: qn_in = 4'd0;
                        endcase
                     end else if (byt_ff != CH_DEL) begin
                        q_in[0] = mk(1'b0, CMD_GLYPH, '0, '0, {1'b0, byt_ff[6:0]});
                        qn_in = 4'd1;
                     end
                  end
                  PS_ESC: begin
                     ps_in = PS_GROUND;
                     case (byt_ff)
                        "[": begin
                           pcnt_in = '0; acc_in = '0; hd_in = 1'b0; priv_in = 1'b0;
                           ps_in = PS_CSI;
                        end
                        "(", ")", "*", "+": ps_in = PS_SKIP;
                        "7": begin sv_in = 1'b1; sv_wr = 1'b1; end
                        "8": if (sv_ff) begin
                           q_in[0] = mk(1'b0, CMD_PLACE, {10'd0, srow_ff},
                                        {10'd0, scol_ff}, '0);
                           q_in[1] = mk(1'b0, CMD_ATTR, '0, '0, sattr_ff);
                           qn_in = 4'd2;
                        end
                        "D": begin q_in[0] = mk(1'b0, CMD_LF, '0, '0, '0); qn_in = 4'd1; end
                        "E": begin q_in[0] = mk(1'b0, CMD_NEWLINE, '0, '0, '0); qn_in = 4'd1; end
                        "M": if (row_ff != 8'd0) begin
                           q_in[0] = mk(1'b0, CMD_PLACE, r - 18'd1, c, '0); qn_in = 4'd1;
                        end
                        "c": begin
                           pcnt_in = '0; acc_in = '0; hd_in = 1'b0; priv_in = 1'b0;
                           sv_in = 1'b0; app_in = 1'b0; ansi_in = 1'b1;
                           q_in[0] = mk(1'b0, CMD_CLEAR, '0, '0, '0);
                           q_in[1] = mk(1'b0, CMD_ATTR, '0, '0, '0);
                           qn_in = 4'd2;
                        end
                        default: ;
                     endcase
                  end
                  PS_CSI: begin
                     if (byt_ff inside {["0":"9"]}) begin
                        prod = {4'd0, acc_ff} * 20'd10 + {16'd0, byt_ff[3:0]};
                        acc_in = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
                        hd_in = 1'b1;
                     end else if (byt_ff == ";") pushf = 1'b1;
                     else if (byt_ff inside {[8'h3C:8'h3F]}) priv_in = 1'b1;
                     else if (byt_ff inside {[8'h20:8'h2F]}) ;
                     else begin pushf = 1'b1; csifin = 1'b1; end
                     if (pushf) begin
                        if (pcnt_ff < PcntW'(MaxParams)) begin
                           pwr = 1'b1; pwa = pcnt_ff[PidxW-1:0];
                           pwd = hd_ff ? acc_ff : 16'd0;
                           pcnt_in = pcnt_ff + 1'b1;
                        end
                        acc_in = '0; hd_in = 1'b0;
                     end
                     if (csifin) begin
                        // dispatch runs next cycle with the pushed parameter
                        ps_in = PS_GROUND; sq_in = SQ_HOLD;
                     end
                  end
                  default: ps_in = PS_GROUND;
               endcase
            end
         end
         SQ_HOLD: begin
            sq_in = SQ_EMIT; qn_in = 4'd0; qi_in = 4'd0;
            case (byt_ff)
               "A": begin q_in[0] = mk(1'b0, CMD_PLACE, r - d0, c, '0); qn_in = 4'd1; end
               "B": begin q_in[0] = mk(1'b0, CMD_PLACE, r + d0, c, '0); qn_in = 4'd1; end
               "C": begin q_in[0] = mk(1'b0, CMD_PLACE, r, c + d0, '0); qn_in = 4'd1; end
               "D": begin q_in[0] = mk(1'b0, CMD_PLACE, r, c - d0, '0); qn_in = 4'd1; end
               "H", "f": begin
                  q_in[0] = mk(1'b0, CMD_PLACE, d0 - 18'd1, d1 - 18'd1, '0); qn_in = 4'd1;
               end
               "J": if (a0 <= 16'd2) begin
                  q_in[0] = mk(1'b0, CMD_ED0 + a0[3:0], '0, '0, '0); qn_in = 4'd1;
               end
               "K": if (a0 <= 16'd2) begin
                  q_in[0] = mk(1'b0, CMD_EL0 + a0[3:0], '0, '0, '0); qn_in = 4'd1;
               end
               "m": begin si_in = '0; sa_in = attr_ff; sq_in = SQ_SGR; end
               "n": begin
                  if (a0 == 16'd6) begin
                     q_in[0] = mk(1'b1, CMD_GLYPH, '0, '0, CH_ESC);
                     q_in[1] = mk(1'b1, CMD_GLYPH, '0, '0, "[");
                     qn_in = 4'd2; dnum_in = {1'b0, row_ff} + 9'd1; dsec_in = 1'b0;
                     dk_in = '0; sq_in = SQ_DIGIT;
                  end else if (a0 == 16'd5) begin
                     q_in[0] = mk(1'b1, CMD_GLYPH, '0, '0, CH_ESC);
                     q_in[1] = mk(1'b1, CMD_GLYPH, '0, '0, "[");
                     q_in[2] = mk(1'b1, CMD_GLYPH, '0, '0, "0");
                     q_in[3] = mk(1'b1, CMD_GLYPH, '0, '0, "n");
                     qn_in = 4'd4;
                  end
               end
               "s": begin sv_in = 1'b1; sv_wr = 1'b1; end
               "u": if (sv_ff) begin
                  q_in[0] = mk(1'b0, CMD_PLACE, {10'd0, srow_ff}, {10'd0, scol_ff}, '0);
                  q_in[1] = mk(1'b0, CMD_ATTR, '0, '0, sattr_ff);
                  qn_in = 4'd2;
               end
               "h", "l": begin
                  if (priv_ff && a0 == 16'd1) app_in = (byt_ff == "h");
                  if (priv_ff && a0 == 16'd2) ansi_in = (byt_ff == "h");
               end
               default: ;
            endcase
         end
         // walk stored parameters, one per cycle
         SQ_SGR: begin
            if (si_ff >= pcnt_ff) begin
               q_in[0] = mk(1'b0, CMD_ATTR, '0, '0, sa_ff); qn_in = 4'd1;
               sq_in = SQ_EMIT;
            end else begin
               case (pstore[si_ff[PidxW-1:0]])
                  16'd0: sa_in = 8'd0;
                  16'd1, 16'd22: sa_in = sa_ff & ~8'h04;
                  16'd2: sa_in = sa_ff | 8'h04;
                  16'd5: sa_in = sa_ff | 8'h02;
                  16'd7: sa_in = sa_ff | 8'h01;
                  16'd25: sa_in = sa_ff & ~8'h02;
                  16'd27: sa_in = sa_ff & ~8'h01;
                  default: ;
               endcase
               si_in = si_ff + 1'b1;
            end
         end
         // decimal unit: one digit per cycle, low digit first
         SQ_DIGIT: begin
            quo = 9'((({9'd0, dnum_ff} * 18'd205) >> 11));
            dval = 4'(dnum_ff - 9'(quo * 9'd10));
            dig_in = {dig_ff[7:0], dval};
            dnum_in = quo;
            dk_in = dk_ff + 2'd1;
            if (quo == 9'd0) begin
               // flush collected digits, most significant first
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) <= dk_ff)
                     q_in[qn_ff + 4'(i)] = mk(1'b1, CMD_GLYPH, '0, '0,
                        8'h30 + {4'd0, (i == 0) ? dval :
                        (i == 1) ? dig_ff[3:0] : dig_ff[7:4]});
               end
               t = mk(1'b1, CMD_GLYPH, '0, '0, dsec_ff ? "R" : ";");
               q_in[qn_ff + {2'd0, dk_ff} + 4'd1] = t;
               qn_in = qn_ff + {2'd0, dk_ff} + 4'd2;
               dk_in = '0; dig_in = '0;
               if (dsec_ff) sq_in = SQ_EMIT;
               else begin dsec_in = 1'b1; dnum_in = {1'b0, col_ff} + 9'd1; end
            end
         end
         // result words through the output register
         SQ_EMIT: begin
            if (qi_ff == qn_ff) sq_in = SQ_IDLE;
            else if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1; ovr_in = q_ff[qi_ff];
               oapp_in = app_ff; oansi_in = ansi_ff;
               ol_in = (qi_ff + 4'd1 == qn_ff);
               qi_in = qi_ff + 4'd1;
               if (qi_ff + 4'd1 == qn_ff) sq_in = SQ_IDLE;
            end
         end
         default: sq_in = SQ_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   // no request taken while result words are still being emitted
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (sq_ff == SQ_EMIT) |-> !req_tready) else $error("ready while emitting");
   // words never outrun the queue
   a_queue: assert property (@(posedge clock) disable iff (reset)
      qi_ff <= qn_ff || sq_ff != SQ_EMIT) else $error("queue overrun");
   // held output stays while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("word dropped");
`endif

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vt100_pkg::*;

   localparam int CycleLimit = 400000;

   // expected result word
   typedef struct {
      logic               kind;
      logic [3:0]         command;
      logic signed [17:0] row;
      logic signed [17:0] col;
      logic [7:0]         value;
      logic               app;
      logic               ansi;
      logic               last;
   } term_word;

   // terminal parser shadow and queue of expected words
   class term_scoreboard;
      parse_type    pstate;
      logic [15:0]  params [MaxParams];
      int unsigned  pcount;
      int unsigned  accum;
      bit           digits_seen;
      bit           private_seen;
      bit           saved_ok;
      logic [7:0]   saved_r, saved_c, saved_a;
      bit           app_keys;
      bit           ansi_on;
      term_word     pending [$];
      term_word     step_words [$];
      int           mismatches;

      function void clear_state();
         pstate = PS_GROUND;
         pcount = 0;
         accum = 0;
         digits_seen = 0;
         private_seen = 0;
         saved_ok = 0;
         app_keys = 0;
         ansi_on = 1;
      endfunction

      function void emit(bit kind, logic [3:0] cmd, int r, int c, logic [7:0] v);
         term_word w;
         w.kind = kind;
         w.command = cmd;
         w.row = r[17:0];
         w.col = c[17:0];
         w.value = v;
         w.app = 0;
         w.ansi = 0;
         w.last = 0;
         step_words = {step_words, w};
      endfunction

      function void emit_decimal(int unsigned n);
         string s;
         s = $sformatf("%0d", n);
         for (int i = 0; i < s.len(); i++) emit(1, CMD_GLYPH, 0, 0, s[i]);
      endfunction

      function int unsigned arg(int i);
         return (i < pcount) ? params[i] : 0;
      endfunction

      function int arg1(int i);
         return (arg(i) == 0) ? 1 : int'(arg(i));
      endfunction

      function void push_arg();
         if (pcount < MaxParams) begin
            params[pcount] = digits_seen ? accum[15:0] : 16'd0;
            pcount++;
         end
         accum = 0;
         digits_seen = 0;
      endfunction

      function void restore();
         if (!saved_ok) return;
         emit(0, CMD_PLACE, saved_r, saved_c, 0);
         emit(0, CMD_ATTR, 0, 0, saved_a);
      endfunction

      function void csi_final(logic [7:0] f, int r, int c, logic [7:0] attr);
         logic [7:0] a;
         int unsigned a0;
         a0 = arg(0);
         case (f)
            "A": emit(0, CMD_PLACE, r - arg1(0), c, 0);
            "B": emit(0, CMD_PLACE, r + arg1(0), c, 0);
            "C": emit(0, CMD_PLACE, r, c + arg1(0), 0);
            "D": emit(0, CMD_PLACE, r, c - arg1(0), 0);
            "H", "f": emit(0, CMD_PLACE, arg1(0) - 1, arg1(1) - 1, 0);
            "J": if (a0 <= 2) emit(0, CMD_ED0 + a0[3:0], 0, 0, 0);
            "K": if (a0 <= 2) emit(0, CMD_EL0 + a0[3:0], 0, 0, 0);
            "m": begin
               a = attr;
               for (int i = 0; i < pcount; i++) begin
                  case (params[i])
                     0: a = 0;
                     1, 22: a &= ~8'h04;
                     2: a |= 8'h04;
                     5: a |= 8'h02;
                     7: a |= 8'h01;
                     25: a &= ~8'h02;
                     27: a &= ~8'h01;
                     default: ;
                  endcase
               end
               emit(0, CMD_ATTR, 0, 0, a);
            end
            "n": begin
               if (a0 == 6) begin
                  emit(1, CMD_GLYPH, 0, 0, CH_ESC);
                  emit(1, CMD_GLYPH, 0, 0, "[");
                  emit_decimal(r + 1);
                  emit(1, CMD_GLYPH, 0, 0, ";");
                  emit_decimal(c + 1);
                  emit(1, CMD_GLYPH, 0, 0, "R");
               end else if (a0 == 5) begin
                  emit(1, CMD_GLYPH, 0, 0, CH_ESC);
                  emit(1, CMD_GLYPH, 0, 0, "[");
                  emit(1, CMD_GLYPH, 0, 0, "0");
                  emit(1, CMD_GLYPH, 0, 0, "n");
               end
            end
            "s": begin
               saved_r = r; saved_c = c; saved_a = attr; saved_ok = 1;
            end
            "u": restore();
            "h", "l": begin
               if (private_seen && a0 == 1) app_keys = (f == "h");
               if (private_seen && a0 == 2) ansi_on = (f == "h");
            end
            default: ;
         endcase
      endfunction

      function void host_byte(logic [7:0] b, logic [7:0] r, logic [7:0] c, logic [7:0] attr);
         case (pstate)
            PS_GROUND: begin
               if (b == CH_ESC) pstate = PS_ESC;
               else if (b < 8'h20) begin
                  case (b)
                     8'h08: emit(0, CMD_BS, 0, 0, 0);
                     8'h09: emit(0, CMD_TAB, 0, 0, 0);
                     8'h0A, 8'h0B, 8'h0C: emit(0, CMD_LF, 0, 0, 0);
                     8'h0D: emit(0, CMD_CR, 0, 0, 0);
                     default: ;
                  endcase
               end else if (b != CH_DEL) emit(0, CMD_GLYPH, 0, 0, {1'b0, b[6:0]});
            end
            PS_ESC: begin
               pstate = PS_GROUND;
               case (b)
                  "[": begin
                     pcount = 0; accum = 0; digits_seen = 0; private_seen = 0;
                     pstate = PS_CSI;
                  end
                  "(", ")", "*", "+": pstate = PS_SKIP;
                  "7": begin
                     saved_r = r; saved_c = c; saved_a = attr; saved_ok = 1;
                  end
                  "8": restore();
                  "D": emit(0, CMD_LF, 0, 0, 0);
                  "E": emit(0, CMD_NEWLINE, 0, 0, 0);
                  "M": if (r > 0) emit(0, CMD_PLACE, int'(r) - 1, c, 0);
                  "c": begin
                     clear_state();
                     emit(0, CMD_CLEAR, 0, 0, 0);
                     emit(0, CMD_ATTR, 0, 0, 0);
                  end
                  default: ;
               endcase
            end
            PS_CSI: begin
               if (b >= "0" && b <= "9") begin
                  accum = accum * 10 + (b - "0");
                  if (accum > 65535) accum = 65535;
                  digits_seen = 1;
               end else if (b == ";") push_arg();
               else if (b >= 8'h3C && b <= 8'h3F) private_seen = 1;
               else if (!(b >= 8'h20 && b <= 8'h2F)) begin
                  push_arg();
                  csi_final(b, r, c, attr);
                  pstate = PS_GROUND;
               end
            end
            default: pstate = PS_GROUND;
         endcase
      endfunction

      // note one accepted request word
      function void note_request(logic [39:0] d, logic key);
         logic [7:0] letters [5];
         letters = '{"A", "B", "C", "D", "H"};
         step_words.delete();
         if (key) begin
            if (d[10:8] < 5) begin
               emit(1, CMD_GLYPH, 0, 0, CH_ESC);
               emit(1, CMD_GLYPH, 0, 0, app_keys ? "O" : "[");
               emit(1, CMD_GLYPH, 0, 0, letters[d[10:8]]);
            end
         end else host_byte(d[7:0], d[18:11], d[26:19], d[34:27]);
         foreach (step_words[i]) begin
            step_words[i].app = app_keys;
            step_words[i].ansi = ansi_on;
            step_words[i].last = (i == step_words.size() - 1);
            pending = {pending, step_words[i]};
         end
      endfunction

      // compare one accepted result word
      function void check_response(logic [55:0] d, logic kind, logic last);
         term_word e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h kind %b last %b", d, kind, last);
            return;
         end
         e = pending.pop_front();
         if (kind !== e.kind || d[3:0] !== e.command || d[21:4] !== e.row ||
             d[39:22] !== e.col || d[47:40] !== e.value || d[48] !== e.app ||
             d[49] !== e.ansi || d[55:50] !== 6'd0 || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp kind %b cmd %0d row %0d col %0d val %h app %b ansi %b last %b; got kind %b cmd %0d row %0d col %0d val %h app %b ansi %b last %b",
                  e.kind, e.command, e.row, e.col, e.value, e.app, e.ansi, e.last,
                  kind, d[3:0], $signed(d[21:4]), $signed(d[39:22]), d[47:40], d[48], d[49],
                  last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   term_scoreboard sb;
   int          send_idle_pct;
   int          recv_stall_pct;
   longint      cycles;

   vt100_escape_parser_top dut (.*);

   // clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random stall and check
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // send one request word, with random idle before it; valid stays up after
   // acceptance so that back-to-back words need only one drive per edge
   task automatic send_word(bit key, logic [7:0] b, logic [2:0] k,
                            logic [7:0] r, logic [7:0] c, logic [7:0] a);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= key;
      req_tdata  <= {5'd0, a, c, r, k, b};
      do @(posedge clock); while (!req_tready);
      sb.note_request(req_tdata, req_tuser);
   endtask

   task automatic send_byte(logic [7:0] b);
      send_word(0, b, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   // one random well-formed or noisy item
   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 12)
         send_word(1, 8'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
      else if (pick < 25) send_byte(8'($urandom));
      else if (pick < 80) begin
         string finals;
         int n;
         finals = "ABCDHfJKmnsuhlXq";
         send_byte(CH_ESC);
         send_byte("[");
         if ($urandom_range(5) == 0) send_byte("?");
         n = $urandom_range(3);
         for (int i = 0; i < n; i++) begin
            int v;
            v = ($urandom_range(4) == 0) ? $urandom_range(99999) : $urandom_range(27);
            if ($urandom_range(6) != 0) send_text($sformatf("%0d", v));
            if (i < n - 1) send_byte(";");
         end
         if ($urandom_range(9) == 0) send_byte(8'(8'h20 + $urandom_range(15)));
         send_byte(($urandom_range(9) == 0) ? 8'($urandom) : finals[$urandom_range(15)]);
      end else begin
         string esc_tails;
         esc_tails = "78DEMc()*+Zq";
         send_byte(CH_ESC);
         send_byte(esc_tails[$urandom_range(11)]);
         if ($urandom_range(1)) send_byte(8'($urandom));
      end
   endtask

   initial begin
      sb = new();
      sb.clear_state();
      sb.mismatches = 0;
      cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: restore before save, controls, glyphs, escapes, csi cases
      send_text({CH_ESC, "8"});
      send_byte(8'h08);
      send_byte(8'h09);
      send_byte(8'h0B);
      send_byte(8'h0D);
      send_byte(8'hFF);
      send_byte(CH_DEL);
      send_byte(8'h00);
      send_word(0, "M", 3'd7, 8'd0, 8'd255, 8'd255);
      send_word(1, 8'hFF, 3'd7, 8'd255, 8'd0, 8'd0);
      send_word(0, CH_ESC, 3'd0, 8'd0, 8'd0, 8'd0);
      send_word(0, "M", 3'd0, 8'd0, 8'd3, 8'd0);
      send_text({CH_ESC, "[99999;1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17m"});
      send_word(0, CH_ESC, 3'd0, 8'd0, 8'd0, 8'd0);
      send_text("[6");
      send_word(0, "n", 3'd0, 8'd255, 8'd255, 8'd0);
      send_text({CH_ESC, "[?1h", CH_ESC, "[?2l"});
      send_word(1, 8'd0, 3'd4, 8'd0, 8'd0, 8'd0);
      send_text({CH_ESC, "c"});

      // random phases with different idle and stall mixes
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 13 : 0;
         recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 13 : 0;
         for (int i = 0; i < 8; i++) random_item();
      end
      req_tvalid <= 1'b0;

      // drain
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

FILE: files.f
rtl/core/vt100_pkg.sv
rtl/core/vt100_escape_parser_top.sv
tb/sv/tb_top.sv
